@@ rtl/blc_pkg.sv @@
`default_nettype none
package blc_pkg;
   localparam int ENTRIES = 32;
   localparam int ID_W = 5;
   localparam int LINK_W = 6;
   localparam int CNT_W = 6;
   localparam int DIM_W = 13;
   localparam int FOOT_W = 27;
   localparam int MAX_POW2_DIM = 2048;
   localparam logic [LINK_W-1:0] NULL_LINK = 6'd63;
   localparam logic [FOOT_W-1:0] FOOT_MAX = {FOOT_W{1'b1}};
   localparam logic [31:0] BUDGET_RESET = 32'd268435456;
   localparam int QDEPTH = 2;

   typedef enum logic [1:0] {
      MODE_USE = 2'd0,
      MODE_FRAME = 2'd1,
      MODE_FREE = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   // classified command passed from front to back
   typedef struct packed {
      mode_type mode;
      logic [ID_W-1:0] id;
      logic [FOOT_W-1:0] foot;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_CLEAR,
      ST_FREE,
      ST_DONE
   } state_type;

   // round a dimension up to a power of two, larger values kept
   function automatic logic [DIM_W-1:0] round_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      r = d;
      for (int i = $clog2(MAX_POW2_DIM); i >= 0; i--) begin
         if (d <= DIM_W'(1 << i)) r = DIM_W'(1 << i);
      end
      return r;
   endfunction
endpackage
`default_nettype wire

@@ rtl/budgeted_lru_texture_cache.sv @@
`default_nettype none
// LRU texture cache bookkeeping with a byte budget. One transaction is in
// flight at a time: busy stays high from acceptance until its last result
// (rsp_last) has been shown, then start is taken again. A use transaction
// passes the footprint stage, queue and list update, result and busy release
// before the next acceptance. Frame end walks the recency list one entry per
// cycle, then switches to clearing and finishes; free-all sweeps all 32
// entries one per cycle. Each result is on the rsp_ ports for one cycle with
// rsp_valid; it must be taken.
module budgeted_lru_texture_cache import blc_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [1:0] req_mode,
   input wire logic [ID_W-1:0] req_entry_id,
   input wire logic [DIM_W-1:0] req_image_width,
   input wire logic [DIM_W-1:0] req_image_height,
   input wire logic csr_we,
   input wire logic [31:0] csr_wdata,
   output logic rsp_valid,
   output logic [ID_W-1:0] rsp_evicted_id,
   output logic rsp_evicted,
   output logic rsp_was_resident,
   output logic [CNT_W-1:0] rsp_loaded_count,
   output logic [31:0] rsp_usage_bytes,
   output logic rsp_last
);
   logic [31:0] budget_ff;
   logic q_valid, pop, done;
   cmd_type q_head;

   // budget register
   always_ff @(posedge clock) begin
      if (reset) budget_ff <= BUDGET_RESET;
      else if (csr_we) budget_ff <= csr_wdata;
   end

   blc_front u_front (
      .clock, .reset, .start, .busy, .req_mode, .req_entry_id,
      .req_image_width, .req_image_height,
      .back_done(done), .pop, .q_valid, .q_head
   );

   blc_back u_back (
      .clock, .reset, .budget(budget_ff), .q_valid, .q_head, .pop, .done,
      .rsp_valid, .rsp_evicted_id, .rsp_evicted, .rsp_was_resident,
      .rsp_loaded_count, .rsp_usage_bytes, .rsp_last
   );
endmodule
`default_nettype wire

@@ rtl/blc_front.sv @@
`default_nettype none
// Accepts transactions, computes load footprint, and pushes to a short queue.
module blc_front import blc_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [1:0] req_mode,
   input wire logic [ID_W-1:0] req_entry_id,
   input wire logic [DIM_W-1:0] req_image_width,
   input wire logic [DIM_W-1:0] req_image_height,
   input wire logic back_done,
   input wire logic pop,
   output logic q_valid,
   output cmd_type q_head
);
   // stage 1: rounded dims
   logic s1_valid_ff, s1_valid_in;
   logic [DIM_W-1:0] s1_w_ff, s1_h_ff;
   logic [1:0] s1_mode_ff;
   logic [ID_W-1:0] s1_id_ff;
   // outstanding transaction: one at a time
   logic pend_ff, pend_in;
   cmd_type q_ff [QDEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic [25:0] prod;
   logic [FOOT_W-1:0] foot;
   cmd_type c;
   logic acc;

   assign acc = start && !pend_ff;
   assign busy = pend_ff;
   assign pend_in = acc ? 1'b1 : (back_done ? 1'b0 : pend_ff);
   assign s1_valid_in = acc;

   // footprint: w*h*4 saturating
   always_comb begin
      prod = 26'(s1_w_ff) * 26'(s1_h_ff);
      if (prod[25]) foot = FOOT_MAX;
      else foot = {prod[24:0], 2'b00};
      c.mode = mode_type'(s1_mode_ff);
      c.id = s1_id_ff;
      c.foot = foot;
   end

   assign cnt_in = cnt_ff + {1'b0, s1_valid_ff} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         s1_valid_ff <= s1_valid_in;
         cnt_ff <= cnt_in;
      end
      if (acc) begin
         s1_w_ff <= round_dim(req_image_width);
         s1_h_ff <= round_dim(req_image_height);
         s1_mode_ff <= req_mode;
         s1_id_ff <= req_entry_id;
      end
      // queue shift on pop, write at tail
      if (pop) q_ff[0] <= q_ff[1];
      if (s1_valid_ff) q_ff[cnt_ff[0] ^ pop] <= c;
   end

   assign q_valid = cnt_ff != 2'd0;
   assign q_head = q_ff[0];
endmodule
`default_nettype wire

@@ rtl/blc_back.sv @@
`default_nettype none
// Executes commands against the recency list and emits results.
module blc_back import blc_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic [31:0] budget,
   input wire logic q_valid,
   input wire cmd_type q_head,
   output logic pop,
   output logic done,
   output logic rsp_valid,
   output logic [ID_W-1:0] rsp_evicted_id,
   output logic rsp_evicted,
   output logic rsp_was_resident,
   output logic [CNT_W-1:0] rsp_loaded_count,
   output logic [31:0] rsp_usage_bytes,
   output logic rsp_last
);
   logic [ENTRIES-1:0] res_ff, res_in, used_ff, used_in;
   logic [LINK_W-1:0] mr_ff [ENTRIES];
   logic [LINK_W-1:0] lr_ff [ENTRIES];
   logic [LINK_W-1:0] mr_in [ENTRIES];
   logic [LINK_W-1:0] lr_in [ENTRIES];
   logic [FOOT_W-1:0] foot_ff [ENTRIES];
   logic [LINK_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0] use_ff, use_in;
   state_type st_ff, st_in;
   logic [LINK_W-1:0] t_ff, t_in;
   logic [CNT_W-1:0] steps_ff, steps_in;
   logic any_ff, any_in;
   logic wr_foot;
   // registered result
   logic ov_ff, ov_in, oe_ff, oe_in, oh_ff, oh_in, ol_ff, ol_in;
   logic [ID_W-1:0] oid_ff, oid_in;
   logic [ID_W-1:0] e;
   logic [LINK_W-1:0] l, m, h;
   logic [32:0] sum;
   logic do_unlink;
   logic [ID_W-1:0] ue;
   logic free_more;

   function automatic logic is_ent(input logic [LINK_W-1:0] x);
      return x < LINK_W'(ENTRIES);
   endfunction

   // any resident entry above the free-all sweep position
   always_comb begin
      free_more = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (i > int'(t_ff)) free_more = free_more | res_ff[i];
      end
   end

   // next state and list updates
   always_comb begin
      res_in = res_ff; used_in = used_ff;
      mr_in = mr_ff; lr_in = lr_ff;
      head_in = head_ff; tail_in = tail_ff;
      cnt_in = cnt_ff; use_in = use_ff;
      st_in = st_ff; t_in = t_ff; steps_in = steps_ff; any_in = any_ff;
      ov_in = 1'b0; oe_in = 1'b0; oh_in = 1'b0; ol_in = 1'b0; oid_in = '0;
      pop = 1'b0; done = 1'b0; wr_foot = 1'b0;
      do_unlink = 1'b0; ue = q_head.id;
      e = q_head.id; l = NULL_LINK; m = NULL_LINK; h = NULL_LINK; sum = '0;
      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               any_in = 1'b0; steps_in = '0; t_in = tail_ff;
               case (q_head.mode)
                  MODE_USE: begin
                     ov_in = 1'b1; ol_in = 1'b1; st_in = ST_DONE;
                     used_in[e] = 1'b1;
                     if (res_ff[e]) begin
                        oh_in = 1'b1;
                        if (head_ff != LINK_W'(e)) begin
                           // unlink then make most recent
                           l = lr_ff[e]; m = mr_ff[e];
                           if (is_ent(l)) mr_in[l[ID_W-1:0]] = m;
                           if (is_ent(m)) lr_in[m[ID_W-1:0]] = l;
                           if (tail_ff == LINK_W'(e)) tail_in = m;
                           h = head_ff;
                           lr_in[e] = h; mr_in[e] = NULL_LINK;
                           if (is_ent(h)) mr_in[h[ID_W-1:0]] = LINK_W'(e);
                           head_in = LINK_W'(e);
                           if (!is_ent(tail_in)) tail_in = LINK_W'(e);
                        end
                     end else begin
                        wr_foot = 1'b1;
                        res_in[e] = 1'b1;
                        cnt_in = cnt_ff + 1'b1;
                        sum = {1'b0, use_ff} + 33'(q_head.foot);
                        use_in = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        h = head_ff;
                        lr_in[e] = h; mr_in[e] = NULL_LINK;
                        if (is_ent(h)) mr_in[h[ID_W-1:0]] = LINK_W'(e);
                        head_in = LINK_W'(e);
                        if (!is_ent(tail_ff)) tail_in = LINK_W'(e);
                     end
                  end
                  MODE_FRAME: st_in = ST_WALK;
                  MODE_FREE: begin st_in = ST_FREE; t_in = '0; end
                  default: begin ov_in = 1'b1; ol_in = 1'b1; st_in = ST_DONE; end
               endcase
            end
         end
         ST_WALK: begin
            if (!is_ent(t_ff) || steps_ff == CNT_W'(ENTRIES)) begin
               st_in = ST_DONE; ol_in = 1'b1; ov_in = !any_ff;
            end else if (used_ff[t_ff[ID_W-1:0]]) begin
               st_in = ST_CLEAR; steps_in = '0;
            end else begin
               t_in = mr_ff[t_ff[ID_W-1:0]];
               steps_in = steps_ff + 1'b1;
               if (use_ff > budget) begin
                  do_unlink = 1'b1; ue = t_ff[ID_W-1:0];
               end
            end
         end
         ST_CLEAR: begin
            if (!is_ent(t_ff) || steps_ff == CNT_W'(ENTRIES)) begin
               st_in = ST_DONE; ol_in = 1'b1; ov_in = !any_ff;
            end else begin
               used_in[t_ff[ID_W-1:0]] = 1'b0;
               t_in = mr_ff[t_ff[ID_W-1:0]];
               steps_in = steps_ff + 1'b1;
            end
         end
         ST_FREE: begin
            if (res_ff[t_ff[ID_W-1:0]]) begin
               do_unlink = 1'b1; ue = t_ff[ID_W-1:0];
            end
            t_in = t_ff + 1'b1;
            if (t_ff == LINK_W'(ENTRIES - 1)) begin
               st_in = ST_DONE; ol_in = 1'b1;
               ov_in = !any_ff && !res_ff[t_ff[ID_W-1:0]];
            end
         end
         ST_DONE: begin
            done = 1'b1; st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
      // eviction of entry ue
      if (do_unlink) begin
         any_in = 1'b1;
         res_in[ue] = 1'b0;
         if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
         use_in = (use_ff >= 32'(foot_ff[ue])) ? use_ff - 32'(foot_ff[ue]) : '0;
         l = lr_ff[ue]; m = mr_ff[ue];
         if (is_ent(l)) mr_in[l[ID_W-1:0]] = m;
         if (is_ent(m)) lr_in[m[ID_W-1:0]] = l;
         if (tail_ff == LINK_W'(ue)) tail_in = m;
         if (head_ff == LINK_W'(ue)) head_in = l;
         lr_in[ue] = NULL_LINK; mr_in[ue] = NULL_LINK;
         ov_in = 1'b1; oe_in = 1'b1; oid_in = ue;
         // last when no further eviction can follow
         if (st_ff == ST_WALK) begin
            ol_in = !(is_ent(t_in) && steps_in != CNT_W'(ENTRIES) &&
                      !used_ff[t_in[ID_W-1:0]] && use_in > budget);
         end else begin
            ol_in = !free_more;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0; used_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            mr_ff[i] <= NULL_LINK; lr_ff[i] <= NULL_LINK;
         end
         head_ff <= NULL_LINK; tail_ff <= NULL_LINK;
         cnt_ff <= '0; use_ff <= '0; st_ff <= ST_IDLE;
         t_ff <= NULL_LINK; steps_ff <= '0; any_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         res_ff <= res_in; used_ff <= used_in;
         mr_ff <= mr_in; lr_ff <= lr_in;
         head_ff <= head_in; tail_ff <= tail_in;
         cnt_ff <= cnt_in; use_ff <= use_in; st_ff <= st_in;
         t_ff <= t_in; steps_ff <= steps_in; any_ff <= any_in; ov_ff <= ov_in;
      end
      if (wr_foot) foot_ff[e] <= q_head.foot;
      oe_ff <= oe_in; oh_ff <= oh_in; ol_ff <= ol_in; oid_ff <= oid_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_evicted_id = oid_ff;
   assign rsp_evicted = oe_ff;
   assign rsp_was_resident = oh_ff;
   assign rsp_last = ol_ff;
   assign rsp_loaded_count = cnt_ff;
   assign rsp_usage_bytes = use_ff;
endmodule
`default_nettype wire
